// ===== design/pmfb_pkg.sv =====
`default_nettype none
package pmfb_pkg;

  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_RECT  = 2'd1;
  localparam logic [1:0] MODE_BLIT  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mem_rd;
    logic mem_wr;
    logic advance;
    logic clear_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic no_work;
    logic last_byte;
    logic read_mode;
  } status_t;

endpackage
`default_nettype wire

// ===== design/pmfb_datapath.sv =====
`default_nettype none
module pmfb_datapath #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pmfb_pkg::cmd_t   cmd,
  output pmfb_pkg::status_t     status,
  input  wire logic [1:0]       mode,
  input  wire logic [7:0]       x_first,
  input  wire logic [7:0]       y_first,
  input  wire logic [7:0]       x_last,
  input  wire logic [7:0]       y_last,
  input  wire logic             color,
  input  wire logic             bg_color,
  input  wire logic [7:0]       column_bits,
  input  wire logic [9:0]       read_index,
  output logic      [7:0]       read_data,
  output logic                  is_read
);

  localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
  localparam int BYTES = DISPLAY_WIDTH * PAGES;
  localparam int AW    = $clog2(BYTES);
  localparam logic [8:0]  WIDTH_9  = 9'(DISPLAY_WIDTH);
  localparam logic [8:0]  HEIGHT_9 = 9'(DISPLAY_HEIGHT);
  localparam logic [7:0]  X_MAX    = 8'(DISPLAY_WIDTH - 1);
  localparam logic [7:0]  Y_MAX    = 8'(DISPLAY_HEIGHT - 1);
  localparam logic [13:0] BYTES_14 = 14'(BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(BYTES - 1);

  logic [7:0] store [BYTES];
  logic [7:0] q;

  // Current item.
  logic          read_mode;
  logic          no_work;
  logic          ridx_ok;
  logic [AW-1:0] ridx_addr;
  logic [7:0]    x_hi, y_lo, y_hi;
  logic [4:0]    page_lo, page_hi;
  logic [7:0]    cur_x;
  logic [4:0]    cur_page;
  logic [7:0]    val_lo, val_hi;
  logic [AW-1:0] clr_addr;

  // Values derived from the incoming item.
  logic [7:0]  x_hi_in, y_hi_in, val_lo_in, val_hi_in, pat;
  logic [15:0] pat16;
  logic [8:0]  y_end;
  logic        no_work_in;
  logic [13:0] ridx_ext;

  always_comb begin
    pat      = (column_bits & {8{color}}) | (~column_bits & {8{bg_color}});
    pat16    = {8'h00, pat} << y_first[2:0];
    y_end    = {1'b0, y_first} + 9'd7;
    ridx_ext = {4'b0000, read_index};
    x_hi_in    = x_first;
    y_hi_in    = y_first;
    val_lo_in  = {8{color}};
    val_hi_in  = {8{color}};
    no_work_in = ({1'b0, x_first} >= WIDTH_9) || ({1'b0, y_first} >= HEIGHT_9);
    case (mode)
      pmfb_pkg::MODE_PIXEL: begin
      end
      pmfb_pkg::MODE_RECT: begin
        x_hi_in = (x_last > X_MAX) ? X_MAX : x_last;
        y_hi_in = (y_last > Y_MAX) ? Y_MAX : y_last;
        if (x_first > x_last || y_first > y_last) begin
          no_work_in = 1'b1;
        end
      end
      pmfb_pkg::MODE_BLIT: begin
        y_hi_in   = (y_end > {1'b0, Y_MAX}) ? Y_MAX : y_end[7:0];
        val_lo_in = pat16[7:0];
        val_hi_in = pat16[15:8];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_mode <= (mode == pmfb_pkg::MODE_READ);
      no_work   <= no_work_in;
      ridx_ok   <= ridx_ext < BYTES_14;
      ridx_addr <= ridx_ext[AW-1:0];
      x_hi      <= x_hi_in;
      y_lo      <= y_first;
      y_hi      <= y_hi_in;
      page_lo   <= y_first[7:3];
      page_hi   <= y_hi_in[7:3];
      cur_x     <= x_first;
      cur_page  <= y_first[7:3];
      val_lo    <= val_lo_in;
      val_hi    <= val_hi_in;
    end else if (cmd.advance) begin
      if (cur_page == page_hi) begin
        cur_page <= page_lo;
        cur_x    <= cur_x + 8'd1;
      end else begin
        cur_page <= cur_page + 5'd1;
      end
    end
  end

  // Byte address and the bits of that byte that the item touches.
  logic [13:0]   addr_full;
  logic [AW-1:0] addr;
  logic [2:0]    lo_b, hi_b;
  logic [7:0]    mask, val, wdata;

  always_comb begin
    addr_full = 14'(cur_page) * 14'(DISPLAY_WIDTH) + 14'(cur_x);
    addr      = addr_full[AW-1:0];
    lo_b      = (cur_page == page_lo) ? y_lo[2:0] : 3'd0;
    hi_b      = (cur_page == page_hi) ? y_hi[2:0] : 3'd7;
    mask      = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
    val       = (cur_page == page_lo) ? val_lo : val_hi;
    wdata     = (q & ~mask) | (val & mask);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      store[clr_addr] <= 8'h00;
    end else if (cmd.mem_wr) begin
      store[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      q <= store[read_mode ? ridx_addr : addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= (read_mode && ridx_ok) ? q : 8'h00;
      is_read   <= read_mode;
    end
  end

  assign status.clear_last = (clr_addr == CLR_LAST);
  assign status.no_work    = no_work;
  assign status.last_byte  = (cur_x == x_hi) && (cur_page == page_hi);
  assign status.read_mode  = read_mode;

endmodule
`default_nettype wire

// ===== design/pmfb_ctrl.sv =====
`default_nettype none
module pmfb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pmfb_pkg::cmd_t         cmd,
  input  wire pmfb_pkg::status_t status
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_WR    = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        if (status.read_mode) begin
          state_next = S_DONE;
        end else if (status.no_work) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.advance = 1'b1;
        if (!status.last_byte) begin
          state_next = S_RD;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/paged_monochrome_framebuffer_engine.sv =====
// Page-organised monochrome framebuffer: DISPLAY_WIDTH columns by
// DISPLAY_HEIGHT rows, stored as one byte per column per 8-row page.
// Input channel (in_valid / in_stall) carries one command per transfer:
// set a pixel, fill a rectangle, blit a vertical column byte, or read a byte.
// Output channel (out_valid / out_stall) returns exactly one result per
// command; read_data and is_read are zero except for a read.
// One command is worked at a time by a controller stepping a byte
// read-modify-write on the single-ported store, a read step then a write step.
// Per command: accept, then for a read a store read and a result step,
// for a draw a store read and a write per byte touched (one for a pixel,
// up to two for a blit over two pages), or one store read if it touches
// nothing. The result register is loaded in the last cycle, so a result
// can be taken the cycle after. After reset the store is cleared one byte
// per cycle, all DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes, with
// in_stall held high. While the receiver stalls, the finished result is
// held; the engine waits with in_stall high once the next command is done.
`default_nettype none
module paged_monochrome_framebuffer_engine #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] x_first,
  input  wire logic [7:0] y_first,
  input  wire logic [7:0] x_last,
  input  wire logic [7:0] y_last,
  input  wire logic       color,
  input  wire logic       bg_color,
  input  wire logic [7:0] column_bits,
  input  wire logic [9:0] read_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] read_data,
  output logic            is_read
);

  pmfb_pkg::cmd_t    cmd;
  pmfb_pkg::status_t status;

  pmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pmfb_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_last      (x_last),
    .y_last      (y_last),
    .color       (color),
    .bg_color    (bg_color),
    .column_bits (column_bits),
    .read_index  (read_index),
    .read_data   (read_data),
    .is_read     (is_read)
  );

endmodule
`default_nettype wire
